[design/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define AE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked during reset too
`define AE_ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[design/ae16_pkg.sv]
// types and constants for the arithmetic encoder
// no dependencies
package ae16_pkg;

  localparam int CODE_BITS_DEF = 16;
  localparam int FLUSH_BITS    = 16;
  localparam int MAX_OUT       = 16;
  localparam int QUEUE_DEPTH   = 2;
  localparam logic [15:0] FOLLOW_MAX = 16'hFFFF;

  // job kinds passed from front to back
  localparam logic [1:0] KIND_ENC   = 2'd0;
  localparam logic [1:0] KIND_FLUSH = 2'd1;
  localparam logic [1:0] KIND_ERR   = 2'd2;

  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  typedef struct packed {
    logic        command;
    logic [13:0] sym_count;
    logic [13:0] count_left;
    logic [13:0] count_total;
  } in_word_t;

  typedef struct packed {
    logic        out_bit;
    logic [15:0] follow_count;
    logic        last;
    logic        error;
  } out_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [13:0] count_left;
    logic [14:0] count_hi;
    logic [13:0] count_total;
  } job_t;

endpackage

[design/ae16_front.sv]
// front end: checks the counts of each word and classifies it as a job
// depends on ae16_pkg
module ae16_front import ae16_pkg::*; #(
  parameter int CODE_BITS = CODE_BITS_DEF
) (
  input  logic     item_valid,
  input  in_word_t item,
  output logic     item_stall,
  output logic     job_valid,
  output job_t     job,
  input  logic     job_stall
);

  localparam int TOTAL_LIMIT = (1 << (CODE_BITS - 2)) - 1;

  logic [14:0] hi;
  logic        bad;

  // cumulative upper count and validity
  always_comb begin
    hi  = {1'b0, item.sym_count} + {1'b0, item.count_left};
    bad = (item.count_total == 14'd0) || (item.sym_count == 14'd0) ||
          (hi > {1'b0, item.count_total}) ||
          (32'(item.count_total) > 32'(TOTAL_LIMIT));
  end

  // job word
  always_comb begin
    job.count_left  = item.count_left;
    job.count_hi    = hi;
    job.count_total = item.count_total;
    if (item.command == CMD_FLUSH) begin
      job.kind = KIND_FLUSH;
    end else if (bad) begin
      job.kind = KIND_ERR;
    end else begin
      job.kind = KIND_ENC;
    end
  end

  assign job_valid  = item_valid;
  assign item_stall = job_stall;

endmodule

[design/ae16_queue.sv]
// short job queue between front and back
// depends on ae16_pkg
module ae16_queue import ae16_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  input  job_t push_job,
  output logic push_stall,
  output logic pop_valid,
  output job_t pop_job,
  input  logic pop_stall
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign push_stall = (fill == CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_job    = entries[rptr];
  assign do_push    = push_valid && !push_stall;
  assign do_pop     = pop_valid && !pop_stall;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_job;
    end
  end

endmodule

[design/ae16_back.sv]
// back end: interval narrowing with two serial dividers, renormalization,
// flush and the output register; depends on ae16_pkg
module ae16_back import ae16_pkg::*; #(
  parameter int CODE_BITS = CODE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      job_valid,
  input  job_t      job,
  output logic      job_stall,
  output logic      result_valid,
  output out_word_t result,
  input  logic      result_stall
);

  localparam int PW = CODE_BITS + 16;
  localparam int SW = $clog2(PW);
  localparam int UP = (CODE_BITS > FLUSH_BITS) ? CODE_BITS - FLUSH_BITS : 0;
  localparam int DN = (CODE_BITS < FLUSH_BITS) ? FLUSH_BITS - CODE_BITS : 0;
  localparam logic [CODE_BITS:0]   RND       = (CODE_BITS + 1)'((1 << UP) - 1);
  localparam logic [SW-1:0]        STEP_LAST = SW'(PW - 1);
  localparam logic [CODE_BITS-1:0] QBIT      = CODE_BITS'(1) << (CODE_BITS - 2);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_REN   = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;
  localparam logic [2:0] S_ERR   = 3'd6;

  logic [2:0]           state;
  job_t                 jr;
  logic [CODE_BITS-1:0] low;
  logic [CODE_BITS-1:0] high;
  logic [15:0]          pend;
  logic [PW-1:0]        dq_a;
  logic [PW-1:0]        dq_b;
  logic [13:0]          rem_a;
  logic [13:0]          rem_b;
  logic [SW-1:0]        step;
  logic [4:0]           gcount;
  logic                 hold_v;
  logic                 hold_bit;
  logic [15:0]          hold_follow;
  logic [15:0]          fv;
  logic [3:0]           fcnt;
  logic                 out_v;
  out_word_t            out_q;

  logic                 out_free;
  logic                 push;
  out_word_t            push_word;
  logic                 adv;
  logic [CODE_BITS:0]   range_w;
  logic [PW-1:0]        prod_a;
  logic [PW-1:0]        prod_b;
  logic [14:0]          rsh_a;
  logic [14:0]          rsh_b;
  logic                 ge_a;
  logic                 ge_b;
  logic [13:0]          rem_a_next;
  logic [13:0]          rem_b_next;
  logic [CODE_BITS:0]   v_ext;
  logic                 e0;
  logic                 e1;
  logic                 settle;
  logic                 fol;
  logic                 need_push;
  logic                 room;
  logic [CODE_BITS-1:0] low_adj;
  logic [CODE_BITS-1:0] high_adj;

  assign job_stall    = (state != S_IDLE);
  assign result_valid = out_v;
  assign result       = out_q;
  assign out_free     = !out_v || !result_stall;

  // range and the two products
  always_comb begin
    range_w = {1'b0, high} - {1'b0, low} + (CODE_BITS + 1)'(1);
    prod_a  = PW'(range_w) * PW'(jr.count_hi);
    prod_b  = PW'(range_w) * PW'(jr.count_left);
  end

  // one restoring step of each divider
  always_comb begin
    rsh_a      = {rem_a, dq_a[PW-1]};
    rsh_b      = {rem_b, dq_b[PW-1]};
    ge_a       = (rsh_a >= {1'b0, jr.count_total});
    ge_b       = (rsh_b >= {1'b0, jr.count_total});
    rem_a_next = ge_a ? 14'(rsh_a - {1'b0, jr.count_total}) : rsh_a[13:0];
    rem_b_next = ge_b ? 14'(rsh_b - {1'b0, jr.count_total}) : rsh_b[13:0];
  end

  // flush value from the low end
  assign v_ext = ({1'b0, low} + RND) >> UP;

  // renormalization decisions
  always_comb begin
    e0        = !high[CODE_BITS-1];
    e1        = low[CODE_BITS-1];
    settle    = e0 || e1;
    fol       = !low[CODE_BITS-1] && low[CODE_BITS-2] &&
                high[CODE_BITS-1] && !high[CODE_BITS-2];
    room      = (gcount < 5'(MAX_OUT));
    need_push = hold_v && room;
    low_adj   = fol && !settle ? (low ^ QBIT) : low;
    high_adj  = fol && !settle ? (high ^ QBIT) : high;
  end

  // result push and step enable
  always_comb begin
    push      = 1'b0;
    adv       = 1'b0;
    push_word = '0;
    unique case (state)
      S_REN: begin
        push_word.out_bit      = hold_bit;
        push_word.follow_count = hold_follow;
        if (settle) begin
          adv  = !need_push || out_free;
          push = need_push && out_free;
        end else if (fol) begin
          adv = 1'b1;
        end else begin
          push_word.last = 1'b1;
          push = hold_v && out_free;
          adv  = !hold_v || out_free;
        end
      end
      S_FLUSH: begin
        push_word.out_bit      = fv[15];
        push_word.follow_count = (fcnt == 4'd0) ? pend : 16'd0;
        push_word.last         = (fcnt == 4'd15);
        push = out_free;
        adv  = out_free;
      end
      S_ERR: begin
        push_word.last  = 1'b1;
        push_word.error = 1'b1;
        push = out_free;
        adv  = out_free;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (push) begin
      out_v <= 1'b1;
    end else if (!result_stall) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_q <= push_word;
    end
  end

  // control sequencer and coder state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      low    <= '0;
      high   <= '1;
      pend   <= '0;
      hold_v <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            jr <= job;
            fv <= 16'(v_ext) << DN;
            fcnt <= '0;
            unique case (job.kind)
              KIND_ENC:   state <= S_MUL;
              KIND_FLUSH: state <= S_FLUSH;
              default:    state <= S_ERR;
            endcase
          end
        end
        S_MUL: begin
          dq_a  <= prod_a;
          dq_b  <= prod_b;
          rem_a <= '0;
          rem_b <= '0;
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          dq_a  <= {dq_a[PW-2:0], ge_a};
          dq_b  <= {dq_b[PW-2:0], ge_b};
          rem_a <= rem_a_next;
          rem_b <= rem_b_next;
          step  <= step + 1'b1;
          if (step == STEP_LAST) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          high   <= CODE_BITS'({1'b0, low} + dq_a[CODE_BITS:0] - (CODE_BITS + 1)'(1));
          low    <= CODE_BITS'({1'b0, low} + dq_b[CODE_BITS:0]);
          gcount <= '0;
          hold_v <= 1'b0;
          state  <= S_REN;
        end
        S_REN: begin
          if (adv) begin
            if (settle || fol) begin
              low  <= {low_adj[CODE_BITS-2:0], 1'b0};
              high <= {high_adj[CODE_BITS-2:0], 1'b1};
            end
            if (settle) begin
              if (room) begin
                hold_v      <= 1'b1;
                hold_bit    <= e1;
                hold_follow <= pend;
                gcount      <= gcount + 1'b1;
              end
              pend <= '0;
            end else if (fol) begin
              if (pend != FOLLOW_MAX) begin
                pend <= pend + 1'b1;
              end
            end else begin
              hold_v <= 1'b0;
              state  <= S_IDLE;
            end
          end
        end
        S_FLUSH: begin
          if (adv) begin
            fv   <= {fv[14:0], 1'b0};
            fcnt <= fcnt + 1'b1;
            if (fcnt == 4'd15) begin
              low   <= '0;
              high  <= '1;
              pend  <= '0;
              state <= S_IDLE;
            end
          end
        end
        S_ERR: begin
          if (adv) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[design/arithmetic_encoder_16bit.sv]
// encode word: taken from the queue, one multiply, the serial divides, one
// update, then one renormalization step per cycle while the output is not
// stalled, and a closing step that ends the word
// flush word: one bit per cycle while the output is not stalled; error word: one word
// a two-word queue lets the next word in while the back end works
// synchronous reset: interval to full range, follow count zero, queue empty
module arithmetic_encoder_16bit import ae16_pkg::*; #(
  parameter int CODE_BITS = CODE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  input  in_word_t  item,
  output logic      item_stall,
  output logic      result_valid,
  output out_word_t result,
  input  logic      result_stall
);

  logic job_in_valid;
  job_t job_in;
  logic job_in_stall;
  logic job_out_valid;
  job_t job_out;
  logic job_out_stall;

  // classify incoming words
  ae16_front #(.CODE_BITS(CODE_BITS)) u_front (
    .item_valid (item_valid),
    .item       (item),
    .item_stall (item_stall),
    .job_valid  (job_in_valid),
    .job        (job_in),
    .job_stall  (job_in_stall)
  );

  // decoupling queue
  ae16_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (job_in_valid),
    .push_job   (job_in),
    .push_stall (job_in_stall),
    .pop_valid  (job_out_valid),
    .pop_job    (job_out),
    .pop_stall  (job_out_stall)
  );

  // coder datapath
  ae16_back #(.CODE_BITS(CODE_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (job_out_valid),
    .job          (job_out),
    .job_stall    (job_out_stall),
    .result_valid (result_valid),
    .result       (result),
    .result_stall (result_stall)
  );

endmodule

[design/ae16_checker.sv]
// port-level checks on the encoder result channel, bound to the top level
// depends on ae16_pkg and assert_macros.svh
`include "assert_macros.svh"

module ae16_checker import ae16_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      result_valid,
  input out_word_t result,
  input logic      result_stall
);

  // a stalled word stays offered
  `AE_ASSERT_IMP(a_hold, clk, rst, $past(result_valid && result_stall) && !$past(rst), result_valid)
  // an error word is always the single last word
  `AE_ASSERT_IMP(a_err_last, clk, rst, result_valid && result.error, result.last)
  // an error word carries no code bit
  `AE_ASSERT_IMP(a_err_zero, clk, rst, result_valid && result.error, !result.out_bit && result.follow_count == 16'd0)
  // nothing offered right after reset
  `AE_ASSERT_NEXT(a_rst_idle, clk, rst, !result_valid)

endmodule

bind arithmetic_encoder_16bit ae16_checker u_ae16_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result       (result),
  .result_stall (result_stall)
);
